### rtl/rdq_pkg.sv
// ----------------------------------------------------------------------------
// rdq_pkg
// Shared types and constants for the record deque with search.
// ----------------------------------------------------------------------------
package rdq_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int CMD_W     = 3;
    localparam int WORD_W    = 32;
    localparam int POS_W     = 7;
    localparam int CNT_W     = 7;
    localparam int STAT_W    = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_HEAD = 3'd0,
        CMD_ADD_TAIL = 3'd1,
        CMD_REM_HEAD = 3'd2,
        CMD_REM_TAIL = 3'd3,
        CMD_READ     = 3'd4,
        CMD_COUNT    = 3'd5,
        CMD_CLEAR    = 3'd6
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic signed [WORD_W-1:0] code;
        logic signed [WORD_W-1:0] quantity;
        logic        [WORD_W-1:0] price_bits;
    } t_record;

endpackage

### rtl/rdq_ifs.sv
// ----------------------------------------------------------------------------
// rdq_ifs
// Command and result channels: valid/ready with payload.
// ----------------------------------------------------------------------------
interface rdq_in_if;
    logic                    valid;
    logic                    ready;
    logic [2:0]              command;
    logic signed [31:0]      item_code;
    logic signed [31:0]      item_quantity;
    logic [31:0]             item_price_bits;
    logic [6:0]              position;

    modport source (
        output valid, command, item_code, item_quantity, item_price_bits, position,
        input  ready
    );
    modport sink (
        input  valid, command, item_code, item_quantity, item_price_bits, position,
        output ready
    );
endinterface

interface rdq_out_if;
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic signed [31:0]      code_read;
    logic [6:0]              match_count;
    logic                    found;
    logic [6:0]              entry_count;

    modport source (
        output valid, status, code_read, match_count, found, entry_count,
        input  ready
    );
    modport sink (
        input  valid, status, code_read, match_count, found, entry_count,
        output ready
    );
endinterface

### rtl/rdq_store.sv
// ----------------------------------------------------------------------------
// rdq_store
// Record memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rdq_store #(
    parameter int DEPTH = rdq_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  rdq_pkg::t_record      i_wdata,
    input  logic                  i_re,
    input  logic [AW-1:0]         i_raddr,
    output rdq_pkg::t_record      o_rdata
);
    import rdq_pkg::*;

    t_record r_mem [DEPTH];
    t_record r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/rdq_ctrl.sv
// ----------------------------------------------------------------------------
// rdq_ctrl
// Command sequencer: ring pointers, code scan, result register.
// ----------------------------------------------------------------------------
module rdq_ctrl #(
    parameter int DEPTH = rdq_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rdq_in_if.sink                i_cmd,
    rdq_out_if.source             o_res,
    output logic                  o_mem_we,
    output logic [AW-1:0]         o_mem_waddr,
    output rdq_pkg::t_record      o_mem_wdata,
    output logic                  o_mem_re,
    output logic [AW-1:0]         o_mem_raddr,
    input  rdq_pkg::t_record      i_mem_rdata
);
    import rdq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    t_state             r_state, n_state;
    t_cmd               r_cmd;
    t_record            r_rec;
    logic [POS_W-1:0]   r_pos;
    logic [AW-1:0]      r_head;
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      r_idx;
    logic [AW-1:0]      r_slot;
    logic [CW-1:0]      r_match;
    logic               r_cmp_vld;
    t_status            r_status;
    logic [WORD_W-1:0]  r_code_rd;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [WORD_W-1:0]  r_out_code;
    logic [CNT_W-1:0]   r_out_match;
    logic               r_out_found;
    logic [CNT_W-1:0]   r_out_cnt;

    logic               accept;
    logic               load_out;
    logic               full;
    logic               empty;
    logic [POS_W-1:0]   pos_eff;
    logic               pos_bad;
    logic [AW-1:0]      head_dec;
    logic [AW-1:0]      head_inc;
    logic [AW-1:0]      tail_slot;
    logic [AW-1:0]      read_slot;
    logic               scan_more;

    assign accept    = i_cmd.valid && i_cmd.ready;
    assign full      = (r_cnt == CW'(DEPTH));
    assign empty     = (r_cnt == '0);
    assign pos_eff   = (r_pos == '0) ? POS_W'(1) : r_pos;
    assign pos_bad   = (PW'(pos_eff) > PW'(r_cnt));
    assign head_dec  = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign head_inc  = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign tail_slot = f_slot(r_head, AW'(r_cnt));
    assign read_slot = f_slot(r_head, AW'(pos_eff - POS_W'(1)));
    assign scan_more = (r_idx != r_cnt);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                case (r_cmd)
                    CMD_READ:  n_state = pos_bad ? ST_FINISH : ST_READ;
                    CMD_COUNT: n_state = ST_SCAN;
                    default:   n_state = ST_FINISH;
                endcase
            end
            ST_READ: n_state = ST_FINISH;
            ST_SCAN: begin
                if (!scan_more) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (load_out) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_cmd.ready = (r_state == ST_IDLE) && i_rst_n;
        load_out    = (r_state == ST_FINISH) && (!r_out_valid || o_res.ready);
        o_mem_we    = (r_state == ST_EXEC) && !full &&
                      ((r_cmd == CMD_ADD_HEAD) || (r_cmd == CMD_ADD_TAIL));
        o_mem_waddr = (r_cmd == CMD_ADD_HEAD) ? head_dec : tail_slot;
        o_mem_wdata = r_rec;
        o_mem_re    = ((r_state == ST_EXEC) && (r_cmd == CMD_READ) && !pos_bad) ||
                      ((r_state == ST_SCAN) && scan_more);
        o_mem_raddr = (r_state == ST_SCAN) ? r_slot : read_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_cnt       <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= (r_state == ST_SCAN) && scan_more;
            if (r_state == ST_EXEC) begin
                case (r_cmd)
                    CMD_ADD_HEAD: begin
                        if (!full) begin
                            r_head <= head_dec;
                            r_cnt  <= r_cnt + CW'(1);
                        end
                    end
                    CMD_ADD_TAIL: begin
                        if (!full) r_cnt <= r_cnt + CW'(1);
                    end
                    CMD_REM_HEAD: begin
                        if (!empty) begin
                            r_head <= head_inc;
                            r_cnt  <= r_cnt - CW'(1);
                        end
                    end
                    CMD_REM_TAIL: begin
                        if (!empty) r_cnt <= r_cnt - CW'(1);
                    end
                    CMD_CLEAR: begin
                        r_head <= '0;
                        r_cnt  <= '0;
                    end
                    default: ;
                endcase
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // beat payload and scan datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd             <= t_cmd'(i_cmd.command);
            r_rec.code        <= i_cmd.item_code;
            r_rec.quantity    <= i_cmd.item_quantity;
            r_rec.price_bits  <= i_cmd.item_price_bits;
            r_pos             <= i_cmd.position;
            r_match           <= '0;
            r_code_rd         <= '0;
        end
        if (r_state == ST_EXEC) begin
            r_idx  <= '0;
            r_slot <= r_head;
            case (r_cmd)
                CMD_ADD_HEAD, CMD_ADD_TAIL: r_status <= full ? STAT_FULL : STAT_OK;
                CMD_REM_HEAD, CMD_REM_TAIL: r_status <= empty ? STAT_EMPTY : STAT_OK;
                CMD_READ:                   r_status <= pos_bad ? STAT_RANGE : STAT_OK;
                default:                    r_status <= STAT_OK;
            endcase
        end
        if (r_state == ST_READ) begin
            r_code_rd <= i_mem_rdata.code;
        end
        if ((r_state == ST_SCAN) && scan_more) begin
            r_idx  <= r_idx + CW'(1);
            r_slot <= f_slot(r_slot, AW'(1));
        end
        if (r_cmp_vld && (i_mem_rdata.code == r_rec.code)) begin
            r_match <= r_match + CW'(1);
        end
        if (load_out) begin
            r_out_status <= r_status;
            r_out_code   <= r_code_rd;
            r_out_match  <= CNT_W'(r_match);
            r_out_found  <= (r_match != '0);
            r_out_cnt    <= CNT_W'(r_cnt);
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out_status;
    assign o_res.code_read   = r_out_code;
    assign o_res.match_count = r_out_match;
    assign o_res.found       = r_out_found;
    assign o_res.entry_count = r_out_cnt;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("held count above depth");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_EXEC))
        else $error("accepted beat not executed");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> r_out_valid)
        else $error("result not presented after load");

    a_match_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH) |-> (r_match <= r_cnt))
        else $error("match count above held count");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out && (r_status == STAT_FULL) |-> full)
        else $error("full status with free slots");

endmodule

### rtl/record_deque_with_search_unit.sv
// ----------------------------------------------------------------------------
// record_deque_with_search_unit
// Bounded deque of records held in a ring buffer, with code read and count.
// ----------------------------------------------------------------------------
// One command beat is taken at a time and returns one result beat. Add,
// remove, clear and out-of-range reads pass through the execute and finish
// states to the result register; an in-range read also passes through the
// read state, which waits for the registered memory read. A count scans
// the held records through the single memory read port, one per cycle.
// A new command beat is accepted once the previous result is registered at
// the output, even while that result waits for the sink. No clearing pass
// follows reset: stored records are only read inside the held range.
module record_deque_with_search_unit #(
    parameter int DEPTH = rdq_pkg::DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rdq_in_if.sink     i_cmd,
    rdq_out_if.source  o_res
);
    import rdq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    t_record        mem_wdata;
    logic           mem_re;
    logic [AW-1:0]  mem_raddr;
    t_record        mem_rdata;

    rdq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_res       (o_res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    rdq_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the record deque with search. A table of directed
// commands covers the empty store, field extremes, wrap of the head, a fill
// to full and every command code. Random command streams that are biased
// toward filling, draining or a mix then follow, in three phases. Every
// accepted command is run through a local deque model; each result beat is
// compared field by field with the oldest pending expectation. The sender
// idles and the receiver stalls at random, except in the last random phase.
// ----------------------------------------------------------------------------
module tb_top;
    import rdq_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 100;
    localparam int N_RANDOM    = 960;
    localparam int SEGMENT_LEN = 40;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    localparam int BIAS_FILL  = 0;
    localparam int BIAS_DRAIN = 1;
    localparam int BIAS_MIX   = 2;

    typedef struct packed {
        t_status                  status;
        logic signed [WORD_W-1:0] code_read;
        logic [CNT_W-1:0]         match_count;
        logic                     found;
        logic [CNT_W-1:0]         entry_count;
    } t_res;

    typedef struct {
        logic [CMD_W-1:0]         cmd;
        logic signed [WORD_W-1:0] code;
        logic signed [WORD_W-1:0] qty;
        logic [WORD_W-1:0]        price;
        logic [POS_W-1:0]         pos;
    } t_cmd_beat;

    typedef struct {
        t_cmd_beat b;
        int        reps;
        bit        typed;
        t_res      r;
    } t_plan_row;

    logic i_clk;
    logic i_rst_n;

    rdq_in_if  cmd_if ();
    rdq_out_if res_if ();

    record_deque_with_search_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    logic signed [WORD_W-1:0] code_mem [DEPTH];
    int        head_slot = 0;
    int        held      = 0;
    t_res      pending_q [$];
    t_plan_row plan [$];
    int        errors        = 0;
    int        quiet_cycles  = 0;
    int        send_idle_pct = 10;
    int        stall_pct     = 47;
    bit        drv_typed;
    t_res      drv_exp;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Deque model: applies one command, returns its result
    function automatic t_res deque_apply(t_cmd_beat b);
        t_res r;
        int   p;
        r = '0;
        r.status = STAT_OK;
        case (b.cmd)
            CMD_ADD_HEAD: begin
                if (held >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    head_slot = (head_slot + DEPTH - 1) % DEPTH;
                    code_mem[head_slot] = b.code;
                    held++;
                end
            end
            CMD_ADD_TAIL: begin
                if (held >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    code_mem[(head_slot + held) % DEPTH] = b.code;
                    held++;
                end
            end
            CMD_REM_HEAD: begin
                if (held == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    head_slot = (head_slot + 1) % DEPTH;
                    held--;
                end
            end
            CMD_REM_TAIL: begin
                if (held == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    held--;
                end
            end
            CMD_READ: begin
                p = (b.pos == 0) ? 1 : int'(b.pos);
                if (p > held) begin
                    r.status = STAT_RANGE;
                end else begin
                    r.code_read = code_mem[(head_slot + p - 1) % DEPTH];
                end
            end
            CMD_COUNT: begin
                for (int i = 0; i < held; i++) begin
                    if (code_mem[(head_slot + i) % DEPTH] == b.code) begin
                        r.match_count++;
                    end
                end
                r.found = (r.match_count != 0);
            end
            CMD_CLEAR: begin
                head_slot = 0;
                held = 0;
            end
            default: ;
        endcase
        r.entry_count = held[CNT_W-1:0];
        return r;
    endfunction

    function automatic logic signed [WORD_W-1:0] rand_code();
        int k;
        k = $urandom_range(0, 19);
        if (k < 15) begin
            return $signed($urandom_range(0, 6)) - 3;
        end else if (k == 15) begin
            return 32'sh7FFFFFFF;
        end else if (k == 16) begin
            return 32'sh80000000;
        end
        return $urandom;
    endfunction

    function automatic t_cmd_beat rand_beat(int bias);
        t_cmd_beat b;
        int        w;
        int        add_w;
        int        rem_w;
        int        k;
        add_w = (bias == BIAS_FILL) ? 65 : (bias == BIAS_DRAIN) ? 15 : 35;
        rem_w = (bias == BIAS_FILL) ? 10 : (bias == BIAS_DRAIN) ? 55 : 30;
        w = $urandom_range(0, 99);
        if (w < add_w) begin
            b.cmd = $urandom_range(0, 1) ? CMD_ADD_TAIL : CMD_ADD_HEAD;
        end else if (w < add_w + rem_w) begin
            b.cmd = $urandom_range(0, 1) ? CMD_REM_TAIL : CMD_REM_HEAD;
        end else begin
            k = $urandom_range(0, 99);
            if (k < 45) begin
                b.cmd = CMD_READ;
            end else if (k < 90) begin
                b.cmd = CMD_COUNT;
            end else if (k < 97) begin
                b.cmd = CMD_CLEAR;
            end else begin
                b.cmd = CMD_UNUSED;
            end
        end
        b.code  = rand_code();
        b.qty   = $urandom;
        b.price = $urandom;
        if ($urandom_range(0, 3) != 0) begin
            b.pos = $urandom_range(0, (held + 1 > DEPTH) ? DEPTH : held + 1);
        end else begin
            b.pos = $urandom_range(0, DEPTH);
        end
        return b;
    endfunction

    function automatic t_plan_row mk(logic [CMD_W-1:0] cmd, logic signed [WORD_W-1:0] code,
                                     logic signed [WORD_W-1:0] qty, logic [WORD_W-1:0] price,
                                     logic [POS_W-1:0] pos, int reps, bit typed, t_status st,
                                     logic signed [WORD_W-1:0] cr, logic [CNT_W-1:0] mc,
                                     logic [CNT_W-1:0] ec);
        t_plan_row row;
        row.b.cmd   = cmd;
        row.b.code  = code;
        row.b.qty   = qty;
        row.b.price = price;
        row.b.pos   = pos;
        row.reps    = reps;
        row.typed   = typed;
        row.r.status      = st;
        row.r.code_read   = cr;
        row.r.match_count = mc;
        row.r.found       = (mc != 0);
        row.r.entry_count = ec;
        return row;
    endfunction

    task automatic send_beat(t_cmd_beat b, bit typed, t_res exp);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            cmd_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        cmd_if.valid           <= 1'b1;
        cmd_if.command         <= b.cmd;
        cmd_if.item_code       <= b.code;
        cmd_if.item_quantity   <= b.qty;
        cmd_if.item_price_bits <= b.price;
        cmd_if.position        <= b.pos;
        drv_typed              <= typed;
        drv_exp                <= exp;
        do begin
            @(posedge i_clk);
        end while (!(cmd_if.valid && cmd_if.ready));
    endtask

    task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(negedge i_clk) begin
        res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin : monitor
        t_res      got;
        t_res      want;
        t_cmd_beat b;
        bit        moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                moved = 1'b1;
                if (pending_q.size() == 0) begin
                    $display("%0t: result beat with none expected, status %0d entries %0d",
                             $time, res_if.status, res_if.entry_count);
                    errors++;
                end else begin
                    want = pending_q.pop_front();
                    check_field("status", want.status, res_if.status);
                    check_field("code_read", want.code_read, res_if.code_read);
                    check_field("match_count", want.match_count, res_if.match_count);
                    check_field("found", want.found, res_if.found);
                    check_field("entry_count", want.entry_count, res_if.entry_count);
                end
            end
            if (cmd_if.valid && cmd_if.ready) begin
                moved   = 1'b1;
                b.cmd   = cmd_if.command;
                b.code  = cmd_if.item_code;
                b.qty   = cmd_if.item_quantity;
                b.price = cmd_if.item_price_bits;
                b.pos   = cmd_if.position;
                got = deque_apply(b);
                pending_q.push_back(drv_typed ? drv_exp : got);
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        t_cmd_beat b;
        int        bias;
        i_rst_n                = 1'b0;
        cmd_if.valid           = 1'b0;
        cmd_if.command         = CMD_CLEAR;
        cmd_if.item_code       = '0;
        cmd_if.item_quantity   = '0;
        cmd_if.item_price_bits = '0;
        cmd_if.position        = '0;
        res_if.ready           = 1'b0;
        drv_typed              = 1'b0;
        drv_exp                = '0;
        bias                   = BIAS_MIX;

        // cmd, code, qty, price, pos, reps, typed, status, code_read, matches, entries
        plan.push_back(mk(CMD_READ,     0, 0, 0, 0, 1, 1, STAT_RANGE, 0, 0, 0));
        plan.push_back(mk(CMD_REM_HEAD, 0, 0, 0, 0, 1, 1, STAT_EMPTY, 0, 0, 0));
        plan.push_back(mk(CMD_REM_TAIL, 0, 0, 0, 0, 1, 1, STAT_EMPTY, 0, 0, 0));
        plan.push_back(mk(CMD_COUNT,    0, 0, 0, 0, 1, 1, STAT_OK,    0, 0, 0));
        plan.push_back(mk(CMD_ADD_TAIL, 32'sh7FFFFFFF, 32'sh80000000, 32'hFFFFFFFF, 0, 1, 1,
                          STAT_OK, 0, 0, 1));
        plan.push_back(mk(CMD_ADD_HEAD, 32'sh80000000, 32'sh7FFFFFFF, 32'h0, 0, 1, 1,
                          STAT_OK, 0, 0, 2));
        plan.push_back(mk(CMD_READ,     0, 0, 0, 0,  1, 1, STAT_OK, 32'sh80000000, 0, 2));
        plan.push_back(mk(CMD_READ,     0, 0, 0, 1,  1, 1, STAT_OK, 32'sh80000000, 0, 2));
        plan.push_back(mk(CMD_READ,     0, 0, 0, 2,  1, 1, STAT_OK, 32'sh7FFFFFFF, 0, 2));
        plan.push_back(mk(CMD_READ,     0, 0, 0, 3,  1, 1, STAT_RANGE, 0, 0, 2));
        plan.push_back(mk(CMD_READ,     0, 0, 0, 64, 1, 1, STAT_RANGE, 0, 0, 2));
        plan.push_back(mk(CMD_ADD_TAIL, -1, 0, 32'h7F800000, 0, 1, 1, STAT_OK, 0, 0, 3));
        plan.push_back(mk(CMD_COUNT,    -1, 0, 0, 0, 1, 1, STAT_OK, 0, 1, 3));
        plan.push_back(mk(CMD_COUNT,    0,  0, 0, 0, 1, 1, STAT_OK, 0, 0, 3));
        plan.push_back(mk(CMD_UNUSED,   0,  0, 0, 0, 1, 1, STAT_OK, 0, 0, 3));
        plan.push_back(mk(CMD_REM_TAIL, 0,  0, 0, 0, 1, 1, STAT_OK, 0, 0, 2));
        plan.push_back(mk(CMD_REM_HEAD, 0,  0, 0, 0, 1, 1, STAT_OK, 0, 0, 1));
        plan.push_back(mk(CMD_READ,     0,  0, 0, 1, 1, 1, STAT_OK, 32'sh7FFFFFFF, 0, 1));
        plan.push_back(mk(CMD_CLEAR,    0,  0, 0, 0, 1, 1, STAT_OK, 0, 0, 0));
        // fill through the head wrap, random records
        plan.push_back(mk(CMD_ADD_HEAD, 0, 0, 0, 0, DEPTH - 1, 0, STAT_OK, 0, 0, 0));
        plan.push_back(mk(CMD_ADD_TAIL, 5, 0, 0, 0, 1, 1, STAT_OK,   0, 0, DEPTH));
        plan.push_back(mk(CMD_ADD_HEAD, 6, 0, 0, 0, 1, 1, STAT_FULL, 0, 0, DEPTH));
        plan.push_back(mk(CMD_ADD_TAIL, 7, 0, 0, 0, 1, 1, STAT_FULL, 0, 0, DEPTH));
        plan.push_back(mk(CMD_READ,     0, 0, 0, 64, 1, 0, STAT_OK,  0, 0, 0));
        plan.push_back(mk(CMD_COUNT,    5, 0, 0, 0,  1, 0, STAT_OK,  0, 0, 0));
        plan.push_back(mk(CMD_CLEAR,    0, 0, 0, 0,  1, 1, STAT_OK,  0, 0, 0));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            for (int n = 0; n < plan[i].reps; n++) begin
                b = plan[i].b;
                if (plan[i].reps > 1) begin
                    b.code  = rand_code();
                    b.qty   = $urandom;
                    b.price = $urandom;
                end
                send_beat(b, plan[i].typed, plan[i].r);
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                send_idle_pct = 47;
                stall_pct     = 10;
            end else if (ph == 2) begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            for (int n = 0; n < N_RANDOM / 3; n++) begin
                if (n % SEGMENT_LEN == 0) begin
                    bias = $urandom_range(BIAS_FILL, BIAS_MIX);
                end
                send_beat(rand_beat(bias), 1'b0, '0);
            end
        end

        @(negedge i_clk);
        cmd_if.valid <= 1'b0;
        while (pending_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/rdq_pkg.sv
rtl/rdq_ifs.sv
rtl/rdq_store.sv
rtl/rdq_ctrl.sv
rtl/record_deque_with_search_unit.sv
verif/tb_top.sv
